FILE: rtl/dsrl_pkg.sv
// shared constants and control structs for the dual slew rate limiter
// no dependencies; compiled first

package dsrl_pkg;

  // speed fields and stored speeds, signed two's complement, 1/64 units
  localparam int SPEED_WIDTH = 16;
  // step magnitude fields, unsigned
  localparam int STEP_WIDTH  = 15;

  // common width for differences, distances and step additions
  localparam int ARITH_WIDTH = ((SPEED_WIDTH > STEP_WIDTH) ? SPEED_WIDTH : STEP_WIDTH) + 1;

  // serial scaler: step * num, two bits of num a cycle, then step * num / den
  localparam int MUL_DIGITS  = (SPEED_WIDTH + 1) / 2;
  localparam int NUM_PAD     = 2 * MUL_DIGITS;
  localparam int PROD_WIDTH  = STEP_WIDTH + SPEED_WIDTH;
  localparam int CNT_SPAN    = (MUL_DIGITS > STEP_WIDTH) ? MUL_DIGITS : STEP_WIDTH;
  localparam int CNT_WIDTH   = $clog2(CNT_SPAN);

  typedef struct packed {
    logic                   start;
    logic [STEP_WIDTH-1:0]  base;
    logic [SPEED_WIDTH-1:0] num;
    logic [SPEED_WIDTH-1:0] den;
  } scale_req_t;

  typedef struct packed {
    logic                  done;
    logic [STEP_WIDTH-1:0] quot;
  } scale_rsp_t;

endpackage

FILE: rtl/dsrl_if.sv
// request and result channels of the dual slew rate limiter
// depends on dsrl_pkg for the field widths

interface dsrl_cmd_if import dsrl_pkg::*; ();
  logic                          valid;
  logic                          ready;
  logic                          mode;
  logic signed [SPEED_WIDTH-1:0] target_left;
  logic signed [SPEED_WIDTH-1:0] target_right;
  logic        [STEP_WIDTH-1:0]  step_left;
  logic        [STEP_WIDTH-1:0]  step_right;

  modport source (
    output valid, mode, target_left, target_right, step_left, step_right,
    input  ready
  );
  modport sink (
    input  valid, mode, target_left, target_right, step_left, step_right,
    output ready
  );
endinterface

interface dsrl_rsp_if import dsrl_pkg::*; ();
  logic                          valid;
  logic                          ready;
  logic signed [SPEED_WIDTH-1:0] speed_left;
  logic signed [SPEED_WIDTH-1:0] speed_right;

  modport source (
    output valid, speed_left, speed_right,
    input  ready
  );
  modport sink (
    input  valid, speed_left, speed_right,
    output ready
  );
endinterface

FILE: rtl/dsrl_scaler.sv
// serial step scaler: floor(base * num / den) for num <= den, den > 0
// radix-4 shift-add multiply, then restoring divide one quotient bit a cycle; uses dsrl_pkg

module dsrl_scaler import dsrl_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  scale_req_t req,
  output scale_rsp_t rsp
);

  localparam logic [1:0] SC_IDLE = 2'd0;
  localparam logic [1:0] SC_MUL  = 2'd1;
  localparam logic [1:0] SC_DIV  = 2'd2;

  logic [1:0]             phase;
  logic [CNT_WIDTH-1:0]   cnt;
  logic [STEP_WIDTH-1:0]  base_r;
  logic [STEP_WIDTH+1:0]  base3;
  logic [NUM_PAD-1:0]     numsr;
  logic [SPEED_WIDTH-1:0] den_r;
  logic [PROD_WIDTH-1:0]  acc;
  logic [SPEED_WIDTH-1:0] rem;
  logic [STEP_WIDTH-1:0]  qsr;
  logic                   done;

  logic [1:0]             digit;
  logic [STEP_WIDTH+1:0]  partial;
  logic [PROD_WIDTH-1:0]  acc_next;
  logic [SPEED_WIDTH:0]   trial;
  logic [SPEED_WIDTH:0]   trial_diff;
  logic                   qbit;

  // multiples of the base step picked by the current digit
  assign digit = numsr[NUM_PAD-1 -: 2];

  always_comb begin
    case (digit)
      2'd0:    partial = '0;
      2'd1:    partial = (STEP_WIDTH+2)'(base_r);
      2'd2:    partial = (STEP_WIDTH+2)'({base_r, 1'b0});
      default: partial = base3;
    endcase
  end

  assign acc_next = (acc << 2) + PROD_WIDTH'(partial);

  // shift in the next dividend bit and try the subtraction
  assign trial      = {rem, qsr[STEP_WIDTH-1]};
  assign trial_diff = trial - {1'b0, den_r};
  assign qbit       = (trial >= {1'b0, den_r});

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= SC_IDLE;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      case (phase)
        SC_IDLE: begin
          if (req.start) begin
            phase <= SC_MUL;
          end
        end
        SC_MUL: begin
          if (cnt == '0) begin
            phase <= SC_DIV;
          end
        end
        SC_DIV: begin
          if (cnt == '0) begin
            phase <= SC_IDLE;
            done  <= 1'b1;
          end
        end
        default: phase <= SC_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (phase)
      SC_IDLE: begin
        base_r <= req.base;
        base3  <= (STEP_WIDTH+2)'(req.base) + (STEP_WIDTH+2)'({req.base, 1'b0});
        numsr  <= NUM_PAD'(req.num);
        den_r  <= req.den;
        acc    <= '0;
        cnt    <= CNT_WIDTH'(MUL_DIGITS - 1);
      end
      SC_MUL: begin
        acc   <= acc_next;
        numsr <= numsr << 2;
        cnt   <= cnt - 1'b1;
        if (cnt == '0) begin
          rem <= acc_next[PROD_WIDTH-1:STEP_WIDTH];
          qsr <= acc_next[STEP_WIDTH-1:0];
          cnt <= CNT_WIDTH'(STEP_WIDTH - 1);
        end
      end
      SC_DIV: begin
        rem <= qbit ? trial_diff[SPEED_WIDTH-1:0] : trial[SPEED_WIDTH-1:0];
        qsr <= {qsr[STEP_WIDTH-2:0], qbit};
        cnt <= cnt - 1'b1;
      end
      default: cnt <= '0;
    endcase
  end

  assign rsp.done = done;
  assign rsp.quot = qsr;

  // a new request only arrives while the unit is free
  a_start_idle: assert property (@(posedge clk) disable iff (rst)
    req.start |-> phase == SC_IDLE)
    else $error("scaler started while busy");

  // the remainder stays below the divisor throughout the divide
  a_rem_bound: assert property (@(posedge clk) disable iff (rst)
    phase == SC_DIV |-> rem < den_r)
    else $error("scaler remainder out of range");

  // with num <= den the scaled step never exceeds the base step
  a_quot_bound: assert property (@(posedge clk) disable iff (rst)
    rsp.done |-> rsp.quot <= base_r)
    else $error("scaled step larger than base step");

endmodule

FILE: rtl/dual_slew_rate_limiter_unit.sv
// top level of the dual slew rate limiter: request/result channels, speed state, sequencing
// depends on dsrl_pkg, dsrl_if (dsrl_cmd_if, dsrl_rsp_if) and dsrl_scaler

// Two-channel speed ramp for a left/right drive. Each request carries a mode, a target and a
// step per channel; the block moves its stored left and right speeds (reset to zero) toward
// the targets and returns the new pair of speeds as one result. In independent mode each
// channel moves by its own step; in balanced mode the channel with the larger remaining
// distance moves by step_left and the other by floor(step_left * smaller / larger), so both
// arrive together (ties count the left channel as larger). A channel within its step lands
// exactly on its target, and a target at the most negative code is pulled in by one, so the
// speeds stay in a symmetric range. The block handles one request at a time. Independent
// requests pass through the difference, compare and apply steps; balanced requests with a
// non-zero distance also wait after the compare step for the serial scaler, which
// multiplies two bits a cycle and then divides one quotient bit a cycle. The result sits
// in an output register, so the block is free to take the next request while a result is
// still waiting; it only holds off its final step while that register is full.

module dual_slew_rate_limiter_unit import dsrl_pkg::*; (
  input logic     clk,
  input logic     rst,
  dsrl_cmd_if.sink   cmd,
  dsrl_rsp_if.source rsp
);

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_DIFF  = 3'd1;
  localparam logic [2:0] ST_CMP   = 3'd2;
  localparam logic [2:0] ST_WAIT  = 3'd3;
  localparam logic [2:0] ST_APPLY = 3'd4;

  localparam logic signed [SPEED_WIDTH-1:0] SPEED_MIN_CODE = {1'b1, {(SPEED_WIDTH-1){1'b0}}};
  localparam logic signed [SPEED_WIDTH-1:0] SPEED_MIN_SAT  = {1'b1, {(SPEED_WIDTH-2){1'b0}}, 1'b1};

  // symmetric range: the most negative code is pulled in by one
  function automatic logic signed [SPEED_WIDTH-1:0] sat_speed(
    input logic signed [SPEED_WIDTH-1:0] raw
  );
    return (raw == SPEED_MIN_CODE) ? SPEED_MIN_SAT : raw;
  endfunction

  logic [2:0] state;

  // latched request
  logic                          mode_r;
  logic signed [SPEED_WIDTH-1:0] targ_l;
  logic signed [SPEED_WIDTH-1:0] targ_r;
  logic        [STEP_WIDTH-1:0]  base_l;
  logic        [STEP_WIDTH-1:0]  base_r;

  // stored speeds
  logic signed [SPEED_WIDTH-1:0] left_speed;
  logic signed [SPEED_WIDTH-1:0] right_speed;

  // per-request working values
  logic signed [ARITH_WIDTH-1:0] delta_l;
  logic signed [ARITH_WIDTH-1:0] delta_r;
  logic        [ARITH_WIDTH-1:0] dist_l;
  logic        [ARITH_WIDTH-1:0] dist_r;
  logic        [STEP_WIDTH-1:0]  step_l;
  logic        [STEP_WIDTH-1:0]  step_r;
  logic                          left_big;

  // output register
  logic                          out_valid;
  logic signed [SPEED_WIDTH-1:0] out_left;
  logic signed [SPEED_WIDTH-1:0] out_right;

  scale_req_t sc_req;
  scale_rsp_t sc_rsp;

  logic                          cmd_fire;
  logic                          slot_free;
  logic signed [ARITH_WIDTH-1:0] cur_lx;
  logic signed [ARITH_WIDTH-1:0] cur_rx;
  logic signed [ARITH_WIDTH-1:0] diff_l;
  logic signed [ARITH_WIDTH-1:0] diff_r;
  logic                          cmp_left_big;
  logic                          need_scale;
  logic        [ARITH_WIDTH-1:0] step_lx;
  logic        [ARITH_WIDTH-1:0] step_rx;
  logic signed [ARITH_WIDTH-1:0] move_l;
  logic signed [ARITH_WIDTH-1:0] move_r;
  logic signed [SPEED_WIDTH-1:0] new_l;
  logic signed [SPEED_WIDTH-1:0] new_r;

  assign cmd.ready = (state == ST_IDLE);
  assign cmd_fire  = cmd.valid && cmd.ready;
  assign slot_free = !out_valid || rsp.ready;

  // signed distance to target, then its magnitude
  assign cur_lx = ARITH_WIDTH'(left_speed);
  assign cur_rx = ARITH_WIDTH'(right_speed);
  assign diff_l = ARITH_WIDTH'(targ_l) - cur_lx;
  assign diff_r = ARITH_WIDTH'(targ_r) - cur_rx;

  // ties go to the left channel
  assign cmp_left_big = (dist_l >= dist_r);
  // nothing to scale when both channels already sit on their targets
  assign need_scale   = mode_r && (!cmp_left_big || (dist_l != '0));

  assign sc_req.start = (state == ST_CMP) && need_scale;
  assign sc_req.base  = base_l;
  assign sc_req.num   = cmp_left_big ? dist_r[SPEED_WIDTH-1:0] : dist_l[SPEED_WIDTH-1:0];
  assign sc_req.den   = cmp_left_big ? dist_l[SPEED_WIDTH-1:0] : dist_r[SPEED_WIDTH-1:0];

  dsrl_scaler u_scaler (
    .clk (clk),
    .rst (rst),
    .req (sc_req),
    .rsp (sc_rsp)
  );

  // final move: snap when within the step, otherwise one step toward the target
  assign step_lx = ARITH_WIDTH'(step_l);
  assign step_rx = ARITH_WIDTH'(step_r);
  assign move_l  = delta_l[ARITH_WIDTH-1] ? cur_lx - $signed(step_lx) : cur_lx + $signed(step_lx);
  assign move_r  = delta_r[ARITH_WIDTH-1] ? cur_rx - $signed(step_rx) : cur_rx + $signed(step_rx);
  assign new_l   = (dist_l <= step_lx) ? targ_l : move_l[SPEED_WIDTH-1:0];
  assign new_r   = (dist_r <= step_rx) ? targ_r : move_r[SPEED_WIDTH-1:0];

  // sequencer and stored speeds
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      left_speed  <= '0;
      right_speed <= '0;
      out_valid   <= 1'b0;
    end else begin
      case (state)
        ST_IDLE: begin
          if (cmd_fire) begin
            state <= ST_DIFF;
          end
        end
        ST_DIFF: begin
          state <= ST_CMP;
        end
        ST_CMP: begin
          state <= need_scale ? ST_WAIT : ST_APPLY;
        end
        ST_WAIT: begin
          if (sc_rsp.done) begin
            state <= ST_APPLY;
          end
        end
        ST_APPLY: begin
          if (slot_free) begin
            left_speed  <= new_l;
            right_speed <= new_r;
            state       <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
      // result register: loaded on the final step, emptied when taken
      if ((state == ST_APPLY) && slot_free) begin
        out_valid <= 1'b1;
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // datapath registers, no reset needed
  always_ff @(posedge clk) begin
    if (cmd_fire) begin
      mode_r <= cmd.mode;
      targ_l <= sat_speed(cmd.target_left);
      targ_r <= sat_speed(cmd.target_right);
      base_l <= cmd.step_left;
      base_r <= cmd.step_right;
    end
    if (state == ST_DIFF) begin
      delta_l <= diff_l;
      delta_r <= diff_r;
      dist_l  <= diff_l[ARITH_WIDTH-1] ? ARITH_WIDTH'(-diff_l) : ARITH_WIDTH'(diff_l);
      dist_r  <= diff_r[ARITH_WIDTH-1] ? ARITH_WIDTH'(-diff_r) : ARITH_WIDTH'(diff_r);
    end
    if (state == ST_CMP) begin
      left_big <= cmp_left_big;
      if (!mode_r) begin
        step_l <= base_l;
        step_r <= base_r;
      end else if (cmp_left_big) begin
        // the right step is filled in by the scaler unless both distances are zero
        step_l <= base_l;
        step_r <= '0;
      end else begin
        step_r <= base_l;
        step_l <= '0;
      end
    end
    if ((state == ST_WAIT) && sc_rsp.done) begin
      if (left_big) begin
        step_r <= sc_rsp.quot;
      end else begin
        step_l <= sc_rsp.quot;
      end
    end
    if ((state == ST_APPLY) && slot_free) begin
      out_left  <= new_l;
      out_right <= new_r;
    end
  end

  assign rsp.valid       = out_valid;
  assign rsp.speed_left  = out_left;
  assign rsp.speed_right = out_right;

  // an accepted request always starts with the difference step
  a_accept_seq: assert property (@(posedge clk) disable iff (rst)
    cmd_fire |=> state == ST_DIFF)
    else $error("accepted request did not start processing");

  // the scaler only reports back while the sequencer waits for it
  a_scale_done: assert property (@(posedge clk) disable iff (rst)
    sc_rsp.done |-> state == ST_WAIT)
    else $error("scaler result arrived outside the wait step");

  // a loaded result mirrors the speeds just stored
  a_result_state: assert property (@(posedge clk) disable iff (rst)
    (state == ST_APPLY) && slot_free |=>
      rsp.valid && (rsp.speed_left == left_speed) && (rsp.speed_right == right_speed))
    else $error("result does not match stored speeds");

endmodule

FILE: sim/dual_slew_rate_limiter_unit_tb.sv
// self-checking testbench for dual_slew_rate_limiter_unit: directed and random speed requests
// depends on dsrl_pkg, dsrl_if (dsrl_cmd_if, dsrl_rsp_if) and the rtl of the unit
`timescale 1ns / 100ps

module dual_slew_rate_limiter_unit_tb;
  import dsrl_pkg::*;

  localparam longint SPEED_MAX      = (longint'(1) << (SPEED_WIDTH - 1)) - 1;
  localparam longint SPEED_MIN_CODE = -(longint'(1) << (SPEED_WIDTH - 1));
  localparam int     WATCHDOG_LIMIT = 3000;  // cycles without any accepted request or result
  localparam int     HOLD_CYCLES    = 400;   // long result-side stall
  localparam int     SETTLE_CYCLES  = 40;    // idle time after the last result before the summary
  localparam int     MAX_REPORTS    = 40;    // printed mismatch lines, all are still counted
  localparam bit     MODE_INDEP     = 1'b0;
  localparam bit     MODE_BALANCED  = 1'b1;

  typedef logic signed [SPEED_WIDTH-1:0] speed_t;
  typedef logic        [STEP_WIDTH-1:0]  step_t;

  typedef struct {
    speed_t left;
    speed_t right;
  } speed_pair_t;

  logic clk = 1'b0;
  logic rst;

  dsrl_cmd_if cmd_ch ();
  dsrl_rsp_if rsp_ch ();

  dual_slew_rate_limiter_unit DUT (
    .clk (clk),
    .rst (rst),
    .cmd (cmd_ch),
    .rsp (rsp_ch)
  );

  always #5 clk = ~clk;

  // predicted speed state, kept wide so the ramp arithmetic never wraps
  longint left_now;
  longint right_now;

  // speeds expected back, oldest first
  speed_pair_t expected_speeds[$];

  int  error_count    = 0;
  int  requests_sent  = 0;
  int  balanced_sent  = 0;
  int  results_seen   = 0;
  int  snaps_seen     = 0;
  bit  no_idle        = 1'b0;  // both sides run flat out while set
  bit  hold_req       = 1'b0;  // asks the result side for one long stall

  // ---------------------------------------------------------------------------
  // speed ramp predictor
  // ---------------------------------------------------------------------------

  // the most negative code is pulled in by one
  function automatic longint clamp_target(input speed_t raw);
    longint v;
    v = longint'(raw);
    if (v < -SPEED_MAX) v = -SPEED_MAX;
    return v;
  endfunction

  function automatic longint dist_of(input longint d);
    return (d < 0) ? -d : d;
  endfunction

  // move one channel by its step, landing on the target when within reach
  function automatic longint move_toward(input longint cur, input longint targ,
                                         input longint stp);
    longint delta;
    delta = targ - cur;
    if (dist_of(delta) <= stp) begin
      if (delta != 0) snaps_seen++;
      return targ;
    end
    return (delta > 0) ? cur + stp : cur - stp;
  endfunction

  function automatic speed_pair_t predict_ramp(input bit mode, input speed_t tl_raw,
                                               input speed_t tr_raw, input step_t sl,
                                               input step_t sr);
    longint      tl, tr, dl, dr, stl, str;
    speed_pair_t res;
    tl = clamp_target(tl_raw);
    tr = clamp_target(tr_raw);
    if (mode == MODE_BALANCED) begin
      // larger distance gets the full base step, the other a truncated share
      dl = dist_of(tl - left_now);
      dr = dist_of(tr - right_now);
      if (dl >= dr) begin
        stl = longint'(sl);
        str = (dl > 0) ? (longint'(sl) * dr) / dl : 0;
      end else begin
        str = longint'(sl);
        stl = (longint'(sl) * dl) / dr;
      end
    end else begin
      stl = longint'(sl);
      str = longint'(sr);
    end
    left_now  = move_toward(left_now, tl, stl);
    right_now = move_toward(right_now, tr, str);
    res.left  = left_now[SPEED_WIDTH-1:0];
    res.right = right_now[SPEED_WIDTH-1:0];
    return res;
  endfunction

  // ---------------------------------------------------------------------------
  // mismatch reporting, request driver, result checker
  // ---------------------------------------------------------------------------

  task automatic report_mismatch(input string what);
    if (error_count < MAX_REPORTS) $display("%0t mismatch: %s", $realtime, what);
    error_count++;
  endtask

  // offers one request, with a random gap first unless no_idle is set, and records its expected speeds
  task automatic send_request(input bit mode, input speed_t tl, input speed_t tr,
                              input step_t sl, input step_t sr);
    if (!no_idle) begin
      while ($urandom_range(0, 99) < 23) begin
        cmd_ch.valid <= 1'b0;
        @(posedge clk);
      end
    end
    cmd_ch.valid        <= 1'b1;
    cmd_ch.mode         <= mode;
    cmd_ch.target_left  <= tl;
    cmd_ch.target_right <= tr;
    cmd_ch.step_left    <= sl;
    cmd_ch.step_right   <= sr;
    @(posedge clk);
    while (!cmd_ch.ready) @(posedge clk);
    expected_speeds.push_back(predict_ramp(mode, tl, tr, sl, sr));
    requests_sent++;
    if (mode == MODE_BALANCED) balanced_sent++;
  endtask

  // sender stops offering until every outstanding result has come back
  task automatic pause_until_drained();
    cmd_ch.valid <= 1'b0;
    wait (expected_speeds.size() == 0);
    @(posedge clk);
  endtask

  always @(posedge clk) begin
    speed_pair_t want;
    if (!rst && rsp_ch.valid && rsp_ch.ready) begin
      results_seen++;
      if (expected_speeds.size() == 0) begin
        report_mismatch($sformatf("unexpected result left %0d right %0d",
                                  rsp_ch.speed_left, rsp_ch.speed_right));
      end else begin
        want = expected_speeds.pop_front();
        if (rsp_ch.speed_left !== want.left)
          report_mismatch($sformatf("result %0d speed_left %0d, expected %0d",
                                    results_seen, rsp_ch.speed_left, want.left));
        if (rsp_ch.speed_right !== want.right)
          report_mismatch($sformatf("result %0d speed_right %0d, expected %0d",
                                    results_seen, rsp_ch.speed_right, want.right));
      end
    end
  end

  // result side: random stalls, flat out when asked, one long hold-off on request
  initial begin
    rsp_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        rsp_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        rsp_ch.ready <= 1'b1;
      end else if (no_idle) begin
        rsp_ch.ready <= 1'b1;
      end else begin
        rsp_ch.ready <= ($urandom_range(0, 99) >= 23);
      end
    end
  end

  // watchdog: any long spell with nothing moving on either channel ends the run
  int quiet_cycles = 0;
  always @(posedge clk) begin
    if ((cmd_ch.valid && cmd_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("timeout: no request or result accepted for %0d cycles", WATCHDOG_LIMIT);
      $display("TEST FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // ---------------------------------------------------------------------------
  // stimulus helpers
  // ---------------------------------------------------------------------------

  // targets: full range, extremes, zero, or a short hop from where the channel is
  function automatic speed_t pick_target(input longint cur);
    longint v;
    case ($urandom_range(0, 5))
      0, 1: v = longint'($signed(16'($urandom)));
      2: begin
        case ($urandom_range(0, 2))
          0: v = SPEED_MAX;
          1: v = -SPEED_MAX;
          default: v = SPEED_MIN_CODE;
        endcase
      end
      3: v = 0;
      default: begin
        v = cur + longint'($urandom_range(0, 400)) - 200;
        if (v > SPEED_MAX) v = SPEED_MAX;
        if (v < SPEED_MIN_CODE) v = SPEED_MIN_CODE;
      end
    endcase
    return v[SPEED_WIDTH-1:0];
  endfunction

  function automatic step_t pick_step();
    case ($urandom_range(0, 5))
      0: return step_t'($urandom);
      1: return '0;
      2: return '1;
      3: return step_t'($urandom_range(1, 64));
      default: return step_t'($urandom_range(1, 3000));
    endcase
  endfunction

  // one ramp: the same request repeated so the channels travel and then land
  task automatic send_ramp(input int reps);
    bit     mode;
    speed_t tl, tr;
    step_t  sl, sr;
    mode = 1'($urandom_range(0, 1));
    tl   = pick_target(left_now);
    tr   = pick_target(right_now);
    sl   = pick_step();
    sr   = pick_step();
    repeat (reps) send_request(mode, tl, tr, sl, sr);
  endtask

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------

  task automatic test_directed();
    // zero step while at target, then zero step with a distance: no movement
    send_request(MODE_INDEP, 16'sd0, 16'sd0, 15'd0, 15'd0);
    send_request(MODE_INDEP, 16'sd32767, -16'sd32767, 15'd0, 15'd0);
    // full steps snap to the extremes; most negative code saturates
    send_request(MODE_INDEP, 16'sd32767, -16'sd32768, 15'h7fff, 15'h7fff);
    // full swing is longer than one step: both channels step to zero first
    send_request(MODE_INDEP, -16'sd32768, 16'sd32767, 15'h7fff, 15'h7fff);
    send_request(MODE_INDEP, -16'sd32768, 16'sd32767, 15'h7fff, 15'h7fff);
    // balanced, from opposite extremes to opposite extremes: equal distances
    send_request(MODE_BALANCED, 16'sd32767, -16'sd32768, 15'h7fff, 15'd0);
    send_request(MODE_BALANCED, 16'sd32767, -16'sd32768, 15'h7fff, 15'd0);
    // balanced with both distances zero
    send_request(MODE_BALANCED, 16'sd32767, -16'sd32767, 15'd100, 15'h7fff);
    // back to rest
    send_request(MODE_INDEP, 16'sd0, 16'sd0, 15'h7fff, 15'h7fff);
    // balanced, equal distances of opposite sign
    send_request(MODE_BALANCED, 16'sd1000, -16'sd1000, 15'd300, 15'd5);
    // balanced, left larger, right scaled
    send_request(MODE_BALANCED, 16'sd2000, -16'sd1000, 15'd300, 15'd0);
    send_request(MODE_INDEP, 16'sd0, 16'sd0, 15'h7fff, 15'h7fff);
    // scaled step truncates to nothing on the right
    send_request(MODE_BALANCED, 16'sd5000, 16'sd3, 15'd1, 15'h7fff);
    // right larger, left share truncates to nothing
    send_request(MODE_BALANCED, 16'sd4, -16'sd5000, 15'd7, 15'd0);
    // right larger with a real left share
    send_request(MODE_BALANCED, -16'sd700, -16'sd5000, 15'd1000, 15'd0);
    // zero base step in balanced mode
    send_request(MODE_BALANCED, 16'sd1234, -16'sd4321, 15'd0, 15'h7fff);
    // balanced land on both targets together
    send_request(MODE_BALANCED, -16'sd700, -16'sd5000, 15'h7fff, 15'd0);
    // independent, alternating step bits and targets at a one-unit distance
    send_request(MODE_INDEP, 16'sh5555, -16'sh2aab, 15'h2aaa, 15'h5555);
    send_request(MODE_INDEP, 16'sh5556, -16'sh2aac, 15'd1, 15'd1);
    // balanced, huge distances on both sides with the full base step
    send_request(MODE_BALANCED, -16'sd32767, 16'sd32767, 15'h7fff, 15'd0);
    send_request(MODE_BALANCED, -16'sd32767, 16'sd32767, 15'h7fff, 15'd0);
    send_request(MODE_BALANCED, -16'sd32767, 16'sd32767, 15'h7fff, 15'd0);
  endtask

  // ramps of random length, with some one-off noise requests mixed in
  task automatic test_random_ramps(input int count);
    int sent;
    int reps;
    sent = 0;
    while (sent < count) begin
      if ($urandom_range(0, 4) == 0) begin
        send_request(1'($urandom_range(0, 1)), speed_t'($urandom), speed_t'($urandom),
                     step_t'($urandom), step_t'($urandom));
        sent++;
      end else begin
        reps = $urandom_range(1, 12);
        send_ramp(reps);
        sent += reps;
      end
    end
  endtask

  task automatic test_back_to_back(input int count);
    int sent;
    int reps;
    no_idle = 1'b1;
    sent = 0;
    while (sent < count) begin
      reps = $urandom_range(1, 8);
      send_ramp(reps);
      sent += reps;
    end
    no_idle = 1'b0;
  endtask

  // result side stalls for a long time while requests keep coming
  task automatic test_output_stall(input int count);
    int sent;
    hold_req = 1'b1;
    sent = 0;
    while (sent < count) begin
      send_ramp(4);
      sent += 4;
    end
  endtask

  // short bursts, each followed by a full drain with the sender quiet
  task automatic test_drain_pauses(input int bursts);
    repeat (bursts) begin
      send_ramp($urandom_range(1, 6));
      send_ramp($urandom_range(1, 6));
      pause_until_drained();
    end
  endtask

  // ---------------------------------------------------------------------------
  // main sequence
  // ---------------------------------------------------------------------------

  initial begin
    rst                 = 1'b1;
    cmd_ch.valid        = 1'b0;
    cmd_ch.mode         = MODE_INDEP;
    cmd_ch.target_left  = '0;
    cmd_ch.target_right = '0;
    cmd_ch.step_left    = '0;
    cmd_ch.step_right   = '0;
    left_now            = 0;
    right_now           = 0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    test_directed();
    test_random_ramps(450);
    test_back_to_back(250);
    test_output_stall(40);
    test_drain_pauses(20);
    test_random_ramps(350);

    cmd_ch.valid <= 1'b0;
    wait (expected_speeds.size() == 0);
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("ran %0d speed requests (%0d balanced, %0d independent), %0d results checked",
             requests_sent, balanced_sent, requests_sent - balanced_sent, results_seen);
    $display("channels landed on their targets %0d times; %0d mismatches",
             snaps_seen, error_count);
    if (error_count == 0 && expected_speeds.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
